// File: sv/rv32im_decode_stage_defines.svh
// ----------------------------------------------------------------------------
// rv32im_decode_stage_defines
// Assertion macros shared by the decode stage RTL.
// ----------------------------------------------------------------------------
`ifndef RV32IM_DECODE_STAGE_DEFINES_SVH
`define RV32IM_DECODE_STAGE_DEFINES_SVH

// Check a condition at every clock edge outside reset
`define DS_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a condition holds in the cycle after a trigger
`define DS_ASSERT_NEXT(lbl, trig, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/rv32d_pkg.sv
// ----------------------------------------------------------------------------
// rv32d_pkg
// Types, codes and the instruction decoder of the RV32IM decode stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rv32d_pkg;

   localparam int NUM_REGS_DEF = 32;
   localparam int XLEN_DEF     = 32;
   localparam int REQ_DATA_W   = 112;
   localparam int RSP_DATA_W   = 152;

   // Downstream and fetch signal codes
   localparam logic [1:0] MODE_ADVANCE = 2'd0;
   localparam logic [1:0] MODE_BLOCK   = 2'd1;
   localparam logic [1:0] MODE_FLUSH   = 2'd2;

   // Opcodes
   localparam logic [6:0] OP_REG    = 7'b0110011;
   localparam logic [6:0] OP_IMM    = 7'b0010011;
   localparam logic [6:0] OP_LOAD   = 7'b0000011;
   localparam logic [6:0] OP_STORE  = 7'b0100011;
   localparam logic [6:0] OP_BRANCH = 7'b1100011;
   localparam logic [6:0] OP_JAL    = 7'b1101111;
   localparam logic [6:0] OP_JALR   = 7'b1100111;
   localparam logic [6:0] OP_AUIPC  = 7'b0010111;
   localparam logic [6:0] OP_LUI    = 7'b0110111;
   localparam logic [6:0] OP_HALT   = 7'b0000000;

   // funct7 values
   localparam logic [6:0] F7_BASE = 7'b0000000;
   localparam logic [6:0] F7_ALT  = 7'b0100000;
   localparam logic [6:0] F7_MUL  = 7'b0000001;

   // Instruction name codes
   localparam logic [5:0] NM_ADD = 6'd0,   NM_SUB = 6'd1,   NM_AND = 6'd2;
   localparam logic [5:0] NM_OR = 6'd3,    NM_XOR = 6'd4,   NM_SLL = 6'd5;
   localparam logic [5:0] NM_SRL = 6'd6,   NM_SRA = 6'd7,   NM_SLT = 6'd8;
   localparam logic [5:0] NM_SLTU = 6'd9,  NM_MUL = 6'd10,  NM_MULH = 6'd11;
   localparam logic [5:0] NM_MULHU = 6'd12, NM_DIV = 6'd13, NM_DIVU = 6'd14;
   localparam logic [5:0] NM_REM = 6'd15,  NM_REMU = 6'd16, NM_ADDI = 6'd17;
   localparam logic [5:0] NM_ANDI = 6'd18, NM_ORI = 6'd19,  NM_XORI = 6'd20;
   localparam logic [5:0] NM_SLTI = 6'd21, NM_SLTIU = 6'd22, NM_SLLI = 6'd23;
   localparam logic [5:0] NM_SRLI = 6'd24, NM_SRAI = 6'd25, NM_LW = 6'd26;
   localparam logic [5:0] NM_SW = 6'd27,   NM_BEQ = 6'd28,  NM_BNE = 6'd29;
   localparam logic [5:0] NM_BGE = 6'd30,  NM_BGEU = 6'd31, NM_BLT = 6'd32;
   localparam logic [5:0] NM_BLTU = 6'd33, NM_JAL = 6'd34,  NM_JALR = 6'd35;
   localparam logic [5:0] NM_AUIPC = 6'd36, NM_LUI = 6'd37, NM_NOP = 6'd38;
   localparam logic [5:0] NM_HALT = 6'd39;

   // Register file source of each entry
   typedef enum logic [1:0] {
      SRC_ZERO = 2'd0,
      SRC_WB   = 2'd1,
      SRC_LINK = 2'd2
   } src_type;

   typedef struct packed {
      logic [5:0]  name;
      logic [4:0]  rd;
      logic [4:0]  rs1;
      logic [4:0]  rs2;
      logic [31:0] imm;
      logic        src1;
      logic        src2;
      logic        link;
   } dec_type;

   function automatic dec_type decode_word(input logic [31:0] w);
      dec_type    d;
      logic [2:0] f3;
      logic [6:0] f7;
      logic [31:0] iimm;
      f3   = w[14:12];
      f7   = w[31:25];
      iimm = {{20{w[31]}}, w[31:20]};
      d    = '0;
      case (w[6:0])
         OP_REG: begin
            d.rd = w[11:7]; d.rs1 = w[19:15]; d.rs2 = w[24:20];
            d.src1 = 1'b1; d.src2 = 1'b1;
            d.name = NM_NOP;
            case (f7)
               F7_BASE: begin
                  case (f3)
                     3'd0: d.name = NM_ADD;
                     3'd1: d.name = NM_SLL;
                     3'd2: d.name = NM_SLT;
                     3'd3: d.name = NM_SLTU;
                     3'd4: d.name = NM_XOR;
                     3'd5: d.name = NM_SRL;
                     3'd6: d.name = NM_OR;
                     default: d.name = NM_AND;
                  endcase
               end
               F7_ALT: begin
                  if (f3 == 3'd0) d.name = NM_SUB;
                  else if (f3 == 3'd5) d.name = NM_SRA;
               end
               F7_MUL: begin
                  case (f3)
                     3'd0: d.name = NM_MUL;
                     3'd1: d.name = NM_MULH;
                     3'd3: d.name = NM_MULHU;
                     3'd4: d.name = NM_DIV;
                     3'd5: d.name = NM_DIVU;
                     3'd6: d.name = NM_REM;
                     3'd7: d.name = NM_REMU;
                     default: d.name = NM_NOP;
                  endcase
               end
               default: d.name = NM_NOP;
            endcase
         end
         OP_IMM: begin
            d.rd = w[11:7]; d.rs1 = w[19:15]; d.src1 = 1'b1;
            d.name = NM_NOP;
            if (f3 == 3'd1 || f3 == 3'd5) begin
               d.imm = {27'd0, w[24:20]};
               if (f3 == 3'd1 && f7 == F7_BASE) d.name = NM_SLLI;
               else if (f3 == 3'd5 && f7 == F7_BASE) d.name = NM_SRLI;
               else if (f3 == 3'd5 && f7 == F7_ALT) d.name = NM_SRAI;
            end else begin
               d.imm = iimm;
               case (f3)
                  3'd0: d.name = NM_ADDI;
                  3'd2: d.name = NM_SLTI;
                  3'd3: d.name = NM_SLTIU;
                  3'd4: d.name = NM_XORI;
                  3'd6: d.name = NM_ORI;
                  default: d.name = NM_ANDI;
               endcase
            end
         end
         OP_LOAD: begin
            d.name = (f3 == 3'd2) ? NM_LW : NM_NOP;
            d.rd = w[11:7]; d.rs1 = w[19:15]; d.imm = iimm; d.src1 = 1'b1;
         end
         OP_STORE: begin
            d.name = (f3 == 3'd2) ? NM_SW : NM_NOP;
            d.rs1 = w[19:15]; d.rs2 = w[24:20]; d.src1 = 1'b1; d.src2 = 1'b1;
            d.imm = {{20{w[31]}}, w[31:25], w[11:7]};
         end
         OP_BRANCH: begin
            case (f3)
               3'd0: d.name = NM_BEQ;
               3'd1: d.name = NM_BNE;
               3'd4: d.name = NM_BLT;
               3'd5: d.name = NM_BGE;
               3'd6: d.name = NM_BLTU;
               3'd7: d.name = NM_BGEU;
               default: d.name = NM_NOP;
            endcase
            d.rs1 = w[19:15]; d.rs2 = w[24:20]; d.src1 = 1'b1; d.src2 = 1'b1;
            d.imm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
         end
         OP_JAL: begin
            d.name = NM_JAL; d.rd = w[11:7]; d.link = 1'b1;
            d.imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
         end
         OP_JALR: begin
            d.name = (f3 == 3'd0) ? NM_JALR : NM_NOP;
            d.rd = w[11:7]; d.rs1 = w[19:15]; d.imm = iimm;
            d.src1 = 1'b1; d.link = 1'b1;
         end
         OP_AUIPC: begin
            d.name = NM_AUIPC; d.rd = w[11:7]; d.imm = {w[31:12], 12'd0};
         end
         OP_LUI: begin
            d.name = NM_LUI; d.rd = w[11:7]; d.imm = {w[31:12], 12'd0};
         end
         OP_HALT: d.name = NM_HALT;
         default: d.name = NM_NOP;
      endcase
      return d;
   endfunction

endpackage

// File: sv/rv32im_decode_stage.sv
// ----------------------------------------------------------------------------
// rv32im_decode_stage
// In-order RV32IM decode stage with a pending-write scoreboard and register file.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one slot per item: downstream mode, the fetched word and a
//   writeback. rsp_* returns exactly one item per request item: a bubble
//   (tuser 0) or an issued instruction (tuser 1) plus the signal for fetch.
//   Each item decodes the word latched by the item before it, or the held word.
//   The response is valid in the cycle after accept. Throughput: one item per
//   cycle while rsp_tready is high; the register file is read for the next item
//   at the edge that accepts the current one, so no port blocks back-to-back items.
//   The register file lives in two 32-entry banks (writeback bank and link
//   bank), each with two registered read ports; a per-entry source map picks
//   the newest copy; same-item writebacks and previous-item writes are bypassed.
//   Reset clears the scoreboard, the source map (all registers read zero) and
//   the slot flags; no clearing pass is needed.
//   When rsp_tready is low the response register holds and req_tready drops
//   until the item is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rv32im_decode_stage_defines.svh"

module rv32im_decode_stage #(
   parameter int NUM_REGS = rv32d_pkg::NUM_REGS_DEF,
   parameter int XLEN     = rv32d_pkg::XLEN_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // mode[1:0] fetch_valid[2] fetch_word[34:3] fetch_addr[66:35] wb_valid[67]
   // wb_index[72:68] wb_value[104:73], zero above
   input  logic [rv32d_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // op_id[5:0] dest_reg[10:6] src1_reg[15:11] src2_reg[20:16]
   // immediate[52:21] src1_data[84:53] src2_data[116:85] pc[148:117]
   // fetch_request[150:149], zero above
   output logic [rv32d_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // out_kind[0]
   output logic                              rsp_tuser
);
   import rv32d_pkg::*;

   localparam int IDX_W = $clog2(NUM_REGS);

   // Request fields
   logic [1:0]       mode;
   logic             fetch_valid;
   logic [XLEN-1:0]  fetch_word, fetch_addr, wb_value;
   logic             wb_valid;
   logic [IDX_W-1:0] wb_index;
   logic             req_accept;

   assign mode        = req_tdata[1:0];
   assign fetch_valid = req_tdata[2];
   assign fetch_word  = req_tdata[34:3];
   assign fetch_addr  = req_tdata[66:35];
   assign wb_valid    = req_tdata[67];
   assign wb_index    = req_tdata[68+IDX_W-1:68];
   assign wb_value    = req_tdata[104:73];

   // Slot and hold state
   logic             latched_valid_ff, latched_valid_in;
   logic [XLEN-1:0]  latched_word_ff, latched_addr_ff;
   logic [XLEN-1:0]  held_word_ff, held_word_in, held_addr_ff, held_addr_in;
   logic [XLEN-1:0]  held_v1_ff, held_v1_in, held_v2_ff, held_v2_in;
   logic             decode_finished_ff, decode_finished_in;
   logic             handed_over_ff, handed_over_in;
   logic [NUM_REGS-1:0] pending_ff, pending_in;
   src_type          src_map_ff [NUM_REGS];
   src_type          src_map_in [NUM_REGS];

   // Register file banks and registered read side
   logic [XLEN-1:0]  wb_bank   [NUM_REGS];
   logic [XLEN-1:0]  link_bank [NUM_REGS];
   logic [XLEN-1:0]  wb_rd1_ff, wb_rd2_ff, link_rd1_ff, link_rd2_ff;
   logic [IDX_W-1:0] raddr1_in, raddr2_in;
   src_type          sel1_ff, sel2_ff;
   logic             byp1_ff, byp1_in, byp2_ff, byp2_in;
   logic [XLEN-1:0]  byp1_val_ff, byp1_val_in, byp2_val_ff, byp2_val_in;

   // Response register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_kind_ff, rsp_kind_in;

   // Step logic
   logic             fresh, resolve, conflict, resolved, issue, wb_write, link_write;
   logic [XLEN-1:0]  cur_word, cur_addr, rv1, rv2, v1, v2, link_value, next_word;
   logic [IDX_W-1:0] rs1_i, rs2_i, rd_i;
   logic [NUM_REGS-1:0] pend_eff;
   logic [1:0]       fetch_req;
   dec_type          dec, out_dec;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      // Apply writeback to the scoreboard and the read values
      wb_write = wb_valid && (wb_index != '0);
      pend_eff = pending_ff;
      if (wb_write) pend_eff[wb_index] = 1'b0;

      fresh    = decode_finished_ff && handed_over_ff;
      cur_word = fresh ? latched_word_ff : held_word_ff;
      cur_addr = fresh ? latched_addr_ff : held_addr_ff;
      dec      = decode_word(cur_word);
      rs1_i    = dec.rs1[IDX_W-1:0];
      rs2_i    = dec.rs2[IDX_W-1:0];
      rd_i     = dec.rd[IDX_W-1:0];

      // Newest copy of each source: same-item writeback, then last-item write
      if (byp1_ff) rv1 = byp1_val_ff;
      else if (sel1_ff == SRC_WB) rv1 = wb_rd1_ff;
      else if (sel1_ff == SRC_LINK) rv1 = link_rd1_ff;
      else rv1 = '0;
      if (wb_write && wb_index == rs1_i) rv1 = wb_value;
      if (byp2_ff) rv2 = byp2_val_ff;
      else if (sel2_ff == SRC_WB) rv2 = wb_rd2_ff;
      else if (sel2_ff == SRC_LINK) rv2 = link_rd2_ff;
      else rv2 = '0;
      if (wb_write && wb_index == rs2_i) rv2 = wb_value;

      v1 = dec.src1 ? rv1 : '0;
      v2 = dec.src2 ? rv2 : '0;

      resolve  = (mode != MODE_FLUSH) && (fresh ? latched_valid_ff : !decode_finished_ff);
      conflict = (dec.src1 && pend_eff[rs1_i]) || (dec.src2 && pend_eff[rs2_i])
                 || (dec.link && pend_eff[rd_i]);
      resolved = resolve && !conflict;
      link_write = resolved && dec.link && (rd_i != '0);
      link_value = cur_addr + XLEN'(4);

      // Hold record and flags
      held_word_in = held_word_ff;
      held_addr_in = held_addr_ff;
      held_v1_in   = held_v1_ff;
      held_v2_in   = held_v2_ff;
      if (fresh) begin
         held_word_in = latched_word_ff;
         held_addr_in = latched_addr_ff;
         held_v1_in   = '0;
         held_v2_in   = '0;
      end
      if (resolved) begin
         held_v1_in = v1;
         held_v2_in = v2;
      end

      issue              = 1'b0;
      decode_finished_in = decode_finished_ff;
      handed_over_in     = handed_over_ff;
      fetch_req          = MODE_ADVANCE;
      if (mode == MODE_FLUSH) begin
         decode_finished_in = 1'b1;
         handed_over_in     = 1'b1;
         fetch_req          = MODE_FLUSH;
      end else if (fresh && !latched_valid_ff) begin
         fetch_req = MODE_ADVANCE;
      end else if (resolve && conflict) begin
         decode_finished_in = 1'b0;
         handed_over_in     = 1'b0;
         fetch_req          = MODE_BLOCK;
      end else if (mode == MODE_ADVANCE) begin
         issue              = 1'b1;
         decode_finished_in = 1'b1;
         handed_over_in     = 1'b1;
      end else begin
         decode_finished_in = 1'b1;
         handed_over_in     = 1'b0;
         fetch_req          = MODE_BLOCK;
      end

      // Mark the destination of an issued instruction (not JAL, JALR or x0)
      out_dec    = dec;
      pending_in = pend_eff;
      if (issue && out_dec.name != NM_JAL && out_dec.name != NM_JALR && rd_i != '0)
         pending_in[rd_i] = 1'b1;

      // Source map after this item's writes
      for (int i = 0; i < NUM_REGS; i++) src_map_in[i] = src_map_ff[i];
      if (wb_write) src_map_in[wb_index] = SRC_WB;
      if (link_write) src_map_in[rd_i] = SRC_LINK;

      latched_valid_in = fetch_valid;

      // Read addresses for the next item
      next_word = (decode_finished_in && handed_over_in) ? fetch_word : held_word_in;
      raddr1_in = next_word[15+IDX_W-1:15];
      raddr2_in = next_word[20+IDX_W-1:20];
      byp1_in     = (link_write && rd_i == raddr1_in) || (wb_write && wb_index == raddr1_in);
      byp1_val_in = (link_write && rd_i == raddr1_in) ? link_value : wb_value;
      byp2_in     = (link_write && rd_i == raddr2_in) || (wb_write && wb_index == raddr2_in);
      byp2_val_in = (link_write && rd_i == raddr2_in) ? link_value : wb_value;

      // Response payload
      rsp_kind_in = issue;
      rsp_data_in = '0;
      rsp_data_in[150:149] = fetch_req;
      if (issue) begin
         rsp_data_in[5:0]     = out_dec.name;
         rsp_data_in[10:6]    = out_dec.rd;
         rsp_data_in[15:11]   = out_dec.rs1;
         rsp_data_in[20:16]   = out_dec.rs2;
         rsp_data_in[52:21]   = out_dec.imm;
         rsp_data_in[84:53]   = held_v1_in;
         rsp_data_in[116:85]  = held_v2_in;
         rsp_data_in[148:117] = held_addr_in;
      end
   end

   // Advance control state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         latched_valid_ff   <= 1'b0;
         decode_finished_ff <= 1'b1;
         handed_over_ff     <= 1'b1;
         pending_ff         <= '0;
         for (int i = 0; i < NUM_REGS; i++) src_map_ff[i] <= SRC_ZERO;
         byp1_ff            <= 1'b0;
         byp2_ff            <= 1'b0;
         sel1_ff            <= SRC_ZERO;
         sel2_ff            <= SRC_ZERO;
      end else if (req_accept) begin
         latched_valid_ff   <= latched_valid_in;
         decode_finished_ff <= decode_finished_in;
         handed_over_ff     <= handed_over_in;
         pending_ff         <= pending_in;
         for (int i = 0; i < NUM_REGS; i++) src_map_ff[i] <= src_map_in[i];
         byp1_ff            <= byp1_in;
         byp2_ff            <= byp2_in;
         sel1_ff            <= src_map_in[raddr1_in];
         sel2_ff            <= src_map_in[raddr2_in];
      end
   end

   // Latch slot and hold payload
   always_ff @(posedge clock) begin
      if (reset) begin
         latched_word_ff <= '0;
         latched_addr_ff <= '0;
      end else if (req_accept) begin
         latched_word_ff <= fetch_word;
         latched_addr_ff <= fetch_addr;
         held_word_ff    <= held_word_in;
         held_addr_ff    <= held_addr_in;
         held_v1_ff      <= held_v1_in;
         held_v2_ff      <= held_v2_in;
         byp1_val_ff     <= byp1_val_in;
         byp2_val_ff     <= byp2_val_in;
      end
   end

   // Writeback bank: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (req_accept) begin
         if (wb_write) wb_bank[wb_index] <= wb_value;
         wb_rd1_ff <= wb_bank[raddr1_in];
         wb_rd2_ff <= wb_bank[raddr2_in];
      end
   end

   // Link bank: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (req_accept) begin
         if (link_write) link_bank[rd_i] <= link_value;
         link_rd1_ff <= link_bank[raddr1_in];
         link_rd2_ff <= link_bank[raddr2_in];
      end
   end

   // Response register: load on accept, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
         rsp_kind_ff <= rsp_kind_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

   // Checks
   `DS_ASSERT_ALWAYS(a_x0_never_pending, !pending_ff[0], "x0 marked pending")
   `DS_ASSERT_NEXT(a_flush_bubble, req_accept && mode == MODE_FLUSH, rsp_tvalid && !rsp_tuser && rsp_tdata[150:149] == MODE_FLUSH, "flush did not answer a bubble")
   `DS_ASSERT_NEXT(a_issue_frees, req_accept && issue, decode_finished_ff && handed_over_ff, "issue left an instruction held")
   `DS_ASSERT_NEXT(a_stall_holds, req_accept && resolve && conflict, !decode_finished_ff && !handed_over_ff && !rsp_tuser, "stall did not hold the instruction")

endmodule
